// ----- sv/ppm_sum_frame_decoder_macros.svh -----
// Assertion macros used by the frame decoder checker.
`ifndef PPM_SUM_FRAME_DECODER_MACROS_SVH
`define PPM_SUM_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/psfd_pkg.sv -----
// Shared constants and control types of the PPM-sum frame decoder.
package psfd_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam int HALF_W     = 15;
    localparam int WIDTH_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int FRAME_W    = 5;
    localparam int MINCH_W    = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANNELS   = 2'd3;

    localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RST = 16'd2700;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST      = 16'd700;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST      = 16'd2300;
    localparam logic [MINCH_W-1:0] MIN_CHANNELS_RST   = 5'd5;

    typedef struct packed {
        logic load_in;
        logic set_sync;
        logic clr_sync;
        logic clr_count;
        logic write_width;
        logic emit_start;
        logic emit_full;
        logic emit_beat;
    } cmd_t;

    typedef struct packed {
        logic half_zero;
        logic gap;
        logic in_window;
        logic in_sync;
        logic count_zero;
        logic count_ge_min;
        logic count_top;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

// ----- sv/psfd_in_if.sv -----
// Pulse input channel: two measured half widths.
interface psfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [psfd_pkg::HALF_W-1:0] first_half_width;
    logic [psfd_pkg::HALF_W-1:0] second_half_width;

    modport source (output valid, output first_half_width, output second_half_width,
                    input ready);
    modport sink (input valid, input first_half_width, input second_half_width,
                  output ready);
endinterface

// ----- sv/psfd_out_if.sv -----
// Channel output channel: one beat per decoded channel.
interface psfd_out_if;
    logic                         valid;
    logic                         ready;
    logic [psfd_pkg::INDEX_W-1:0] channel_index;
    logic [psfd_pkg::WIDTH_W-1:0] channel_width;
    logic [psfd_pkg::FRAME_W-1:0] frame_channels;
    logic                         last;

    modport source (output valid, output channel_index, output channel_width,
                    output frame_channels, output last, input ready);
    modport sink (input valid, input channel_index, input channel_width,
                  input frame_channels, input last, output ready);
endinterface

// ----- sv/ppm_sum_frame_decoder.sv -----
// PPM-sum frame decoder: top level joining controller and datapath.
//
// pulse: one beat per measured pulse (two half widths, microseconds).
// chan:  one beat per channel of a decoded frame, in order, last on the final one.
// cfg:   register writes (sync threshold, width limits, minimum channel count),
//        taken when cfg_we is high; write only while the decoder is idle.
// A pulse is accepted in the idle state and evaluated in the next cycle. When
// a pulse ends a frame of N channels, the channels are then read from the
// width store one per cycle, while the output is free, into the output
// register; the rate is set by the single read port of the width store.
// pulse.ready is low while a pulse is evaluated or a frame is being sent.
// When chan.ready is low, emission pauses with the beat held in the output
// register; a beat still waiting does not keep a new pulse from being taken.
// Reset restores the register defaults, drops sync and clears the channel
// count; the width store is not cleared and needs no pass.
module ppm_sum_frame_decoder #(
    parameter int MAX_CHANNELS = psfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psfd_in_if.sink                         pulse,
    psfd_out_if.source                      chan,
    input  logic                            cfg_we,
    input  logic [psfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    psfd_pkg::cmd_t    cmd;
    psfd_pkg::status_t status;
    logic              in_ready;

    assign pulse.ready = in_ready;

    psfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pulse.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    psfd_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .first_half_width  (pulse.first_half_width),
        .second_half_width (pulse.second_half_width),
        .out_ready         (chan.ready),
        .out_valid         (chan.valid),
        .channel_index     (chan.channel_index),
        .channel_width     (chan.channel_width),
        .frame_channels    (chan.frame_channels),
        .last              (chan.last),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

// ----- sv/psfd_dp.sv -----
// Datapath: config registers, pulse sum and checks, width store, output register.
module psfd_dp #(
    parameter int MAX_CHANNELS = psfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [psfd_pkg::HALF_W-1:0]     first_half_width,
    input  logic [psfd_pkg::HALF_W-1:0]     second_half_width,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [psfd_pkg::INDEX_W-1:0]    channel_index,
    output logic [psfd_pkg::WIDTH_W-1:0]    channel_width,
    output logic [psfd_pkg::FRAME_W-1:0]    frame_channels,
    output logic                            last,
    input  psfd_pkg::cmd_t                  cmd,
    output psfd_pkg::status_t               status
);
    localparam int CW   = $clog2(MAX_CHANNELS + 1);
    localparam int AW   = $clog2(MAX_CHANNELS);
    localparam int CMPW = (CW > psfd_pkg::MINCH_W) ? CW : psfd_pkg::MINCH_W;

    logic [psfd_pkg::WIDTH_W-1:0] sync_thr_reg;
    logic [psfd_pkg::WIDTH_W-1:0] min_width_reg;
    logic [psfd_pkg::WIDTH_W-1:0] max_width_reg;
    logic [psfd_pkg::MINCH_W-1:0] min_ch_reg;

    logic [psfd_pkg::HALF_W-1:0]  a_reg;
    logic [psfd_pkg::HALF_W-1:0]  b_reg;
    logic [psfd_pkg::WIDTH_W-1:0] sum;

    logic                         in_sync_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                frame_count_reg;
    logic [AW-1:0]                emit_k_reg;

    logic                         out_valid_reg;
    logic [psfd_pkg::INDEX_W-1:0] out_index_reg;
    logic [psfd_pkg::WIDTH_W-1:0] out_width_reg;
    logic [psfd_pkg::FRAME_W-1:0] out_frame_reg;
    logic                         out_last_reg;

    logic [psfd_pkg::WIDTH_W-1:0] width_mem [MAX_CHANNELS];

    assign sum = {1'b0, a_reg} + {1'b0, b_reg};

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        else if (cmd.write_width)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        status.half_zero    = (a_reg == '0) || (b_reg == '0);
        status.gap          = (sum >= sync_thr_reg);
        status.in_window    = (sum > min_width_reg) && (sum < max_width_reg);
        status.in_sync      = in_sync_reg;
        status.count_zero   = (count_reg == '0);
        status.count_ge_min = (CMPW'(count_reg) >= CMPW'(min_ch_reg));
        status.count_top    = (count_reg == CW'(MAX_CHANNELS - 1));
        status.emit_last    = ((CW'(emit_k_reg) + CW'(1)) == frame_count_reg);
        status.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_thr_reg  <= psfd_pkg::SYNC_THRESHOLD_RST;
            min_width_reg <= psfd_pkg::MIN_WIDTH_RST;
            max_width_reg <= psfd_pkg::MAX_WIDTH_RST;
            min_ch_reg    <= psfd_pkg::MIN_CHANNELS_RST;
            in_sync_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    psfd_pkg::REG_SYNC_THRESHOLD: sync_thr_reg  <= cfg_data;
                    psfd_pkg::REG_MIN_WIDTH:      min_width_reg <= cfg_data;
                    psfd_pkg::REG_MAX_WIDTH:      max_width_reg <= cfg_data;
                    psfd_pkg::REG_MIN_CHANNELS:
                        min_ch_reg <= cfg_data[psfd_pkg::MINCH_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_sync)
            begin
                in_sync_reg <= 1'b0;
            end
            else if (cmd.set_sync)
            begin
                in_sync_reg <= 1'b1;
            end
            count_reg <= count_next;
            if (cmd.emit_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the width store.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= first_half_width;
            b_reg <= second_half_width;
        end
        if (cmd.write_width)
        begin
            width_mem[count_reg[AW-1:0]] <= sum;
        end
        if (cmd.emit_start)
        begin
            frame_count_reg <= cmd.emit_full ? CW'(MAX_CHANNELS) : count_reg;
            emit_k_reg      <= '0;
        end
        else if (cmd.emit_beat)
        begin
            emit_k_reg <= emit_k_reg + AW'(1);
        end
        if (cmd.emit_beat)
        begin
            out_index_reg <= psfd_pkg::INDEX_W'(emit_k_reg);
            out_width_reg <= width_mem[emit_k_reg];
            out_frame_reg <= psfd_pkg::FRAME_W'(frame_count_reg);
            out_last_reg  <= status.emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_index  = out_index_reg;
    assign channel_width  = out_width_reg;
    assign frame_channels = out_frame_reg;
    assign last           = out_last_reg;

endmodule

// ----- sv/psfd_ctrl.sv -----
// Controller: takes a pulse, decides its effect, then sequences frame emission.
module psfd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psfd_pkg::status_t status,
    output psfd_pkg::cmd_t    cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                if (status.half_zero)
                begin
                    cmd.clr_sync  = 1'b1;
                    cmd.clr_count = 1'b1;
                end
                else if (status.gap)
                begin
                    cmd.set_sync  = 1'b1;
                    cmd.clr_count = 1'b1;
                    if (status.in_sync && status.count_ge_min && !status.count_zero)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
                else if (status.in_sync && status.in_window)
                begin
                    cmd.write_width = 1'b1;
                    // storing the last slot fills the frame: emit and drop sync
                    if (status.count_top)
                    begin
                        cmd.clr_count  = 1'b1;
                        cmd.clr_sync   = 1'b1;
                        cmd.emit_start = 1'b1;
                        cmd.emit_full  = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_beat = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/psfd_checker.sv -----
// Port-level checks for the PPM-sum frame decoder, bound to the top level.
`include "ppm_sum_frame_decoder_macros.svh"

module psfd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [psfd_pkg::INDEX_W-1:0] channel_index,
    input logic [psfd_pkg::FRAME_W-1:0] frame_channels,
    input logic                         last
);
    logic [psfd_pkg::INDEX_W-1:0] last_index;

    assign last_index = psfd_pkg::INDEX_W'(frame_channels - 5'd1);

    // a beat offered must wait until taken
    `PSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped")

    // the final beat carries the index one below the frame size
    `PSFD_ASSERT_IMPL(a_last_index, out_valid && last, channel_index == last_index, "bad last index")

    // while a non-final beat is offered the rest of the frame is still owed
    `PSFD_ASSERT_IMPL(a_no_pulse_mid_frame, out_valid && !last, !in_ready, "ready mid frame")

endmodule

bind ppm_sum_frame_decoder psfd_checker u_psfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (pulse.ready),
    .out_valid      (chan.valid),
    .out_ready      (chan.ready),
    .channel_index  (chan.channel_index),
    .frame_channels (chan.frame_channels),
    .last           (chan.last)
);
